>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define SWMN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is held.
`define SWMN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define SWMN_ASSERT_ALWAYS_NXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/swmn_pkg.sv
// Package with constants, codes and control types of the mean normalizer.
package swmn_pkg;

    localparam int FEATURE_DIM   = 40;
    localparam int WINDOW_FRAMES = 512;
    localparam int SUM_BITS      = 29;

    localparam int DIM_W      = 7;
    localparam int FEAT_W     = 16;
    localparam int GSUM_W     = 48;
    localparam int SMOOTH_W   = 13;
    localparam int GC_W       = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int MODE_W     = 2;

    localparam int FD_AW      = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1;
    localparam int HIST_DEPTH = WINDOW_FRAMES * FEATURE_DIM;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(WINDOW_FRAMES + 1);
    localparam int CG_CMP_W   = (SMOOTH_W > CNT_W) ? SMOOTH_W : CNT_W;
    localparam int DEN_W      = GC_W + CNT_W;
    localparam int ACC_W      = 64;
    localparam int Q_W        = 18;
    localparam int DIV_SHIFT  = Q_W - 1;
    localparam int DCNT_W     = $clog2(Q_W);

    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FEAT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NEW  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GCOUNT = 1'd1;

    localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 13'd200;
    localparam logic [GC_W-1:0]     GC_RESET     = 32'd1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SUM,
        OP_MSTEP,
        OP_DEN,
        OP_T1,
        OP_T2,
        OP_T3,
        OP_DPRE,
        OP_DSTEP,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        logic   in_accept;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic feat_start;
        logic mul_zero;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

>>> rtl/core/swmn_if.sv
// Channel interfaces for input items, results and configuration writes.
interface swmn_in_if;
    logic                                valid;
    logic                                ready;
    logic [swmn_pkg::MODE_W-1:0]         mode;
    logic [swmn_pkg::DIM_W-1:0]          dim_index;
    logic signed [swmn_pkg::FEAT_W-1:0]  feature_value;
    logic signed [swmn_pkg::GSUM_W-1:0]  global_sum_value;
    logic                                frame_last;

    modport source (output valid, mode, dim_index, feature_value, global_sum_value,
                     frame_last, input ready);
    modport sink (input valid, mode, dim_index, feature_value, global_sum_value,
                  frame_last, output ready);
endinterface

interface swmn_out_if;
    logic                                valid;
    logic                                ready;
    logic [swmn_pkg::DIM_W-1:0]          out_dim_index;
    logic signed [swmn_pkg::FEAT_W-1:0]  normalized_value;
    logic                                out_frame_last;

    modport source (output valid, out_dim_index, normalized_value, out_frame_last,
                    input ready);
    modport sink (input valid, out_dim_index, normalized_value, out_frame_last,
                  output ready);
endinterface

interface swmn_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [swmn_pkg::CFG_IDX_W-1:0]      index;
    logic [swmn_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/swmn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swmn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/swmn_datapath.sv
// Datapath: window state, memories, shared shift-add multiplier, divider, output register.
module swmn_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swmn_pkg::t_dp_cmd                   i_cmd,
    output swmn_pkg::t_dp_status                o_status,
    input  logic [swmn_pkg::MODE_W-1:0]         i_mode,
    input  logic [swmn_pkg::DIM_W-1:0]          i_dim,
    input  logic signed [swmn_pkg::FEAT_W-1:0]  i_feat,
    input  logic signed [swmn_pkg::GSUM_W-1:0]  i_gsum,
    input  logic                                i_last,
    input  logic                                i_cfg_we,
    input  logic [swmn_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [swmn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [swmn_pkg::DIM_W-1:0]          o_out_dim,
    output logic signed [swmn_pkg::FEAT_W-1:0]  o_out_value,
    output logic                                o_out_last
);

    localparam int FD   = swmn_pkg::FEATURE_DIM;
    localparam int WF   = swmn_pkg::WINDOW_FRAMES;
    localparam int SB   = swmn_pkg::SUM_BITS;
    localparam int AW   = swmn_pkg::ACC_W;
    localparam int DW   = swmn_pkg::DEN_W;
    localparam int CW   = swmn_pkg::CNT_W;
    localparam int HAW  = swmn_pkg::HIST_AW;
    localparam int FAW  = swmn_pkg::FD_AW;
    localparam int QW   = swmn_pkg::Q_W;
    localparam int FW   = swmn_pkg::FEAT_W;

    // Configuration.
    logic [swmn_pkg::SMOOTH_W-1:0] r_smooth;
    logic [swmn_pkg::GC_W-1:0]     r_gc;

    // Window control and validity of the small stores.
    logic [CW-1:0]  r_frames;
    logic [HAW-1:0] r_base;
    logic [FD-1:0]  r_wvalid;
    logic [FD-1:0]  r_gvalid;

    // Latched item.
    logic [swmn_pkg::DIM_W-1:0] r_d;
    logic signed [FW-1:0]       r_x;
    logic                       r_last;
    logic [HAW-1:0]             r_hist_addr;

    // Arithmetic.
    logic signed [SB-1:0]   r_s;
    logic [CW-1:0]          r_cg;
    logic [DW-1:0]          r_den;
    logic [AW-1:0]          r_ma;
    logic [DW-1:0]          r_mb;
    logic [AW-1:0]          r_acc;
    logic [AW-1:0]          r_num;
    logic [AW-1:0]          r_m;
    logic [AW-1:0]          r_rem;
    logic [AW-1:0]          r_dsh;
    logic [QW-1:0]          r_q;
    logic [swmn_pkg::DCNT_W-1:0] r_dcnt;
    logic                   r_neg;
    logic                   r_ovf;

    logic                   r_out_valid;
    logic [swmn_pkg::DIM_W-1:0] r_out_dim;
    logic signed [FW-1:0]   r_out_value;
    logic                   r_out_last;

    // Memory ports.
    logic [SB-1:0]                 w_wrdata;
    logic [swmn_pkg::GSUM_W-1:0]   w_grdata;
    logic [FW-1:0]                 w_hrdata;
    logic                          w_sum_we;
    logic                          w_g_we;

    logic                          w_in_ok;
    logic                          w_cur_ok;
    logic [FAW-1:0]                w_cur_idx;
    logic                          w_close;
    logic                          w_full;
    logic [CW-1:0]                 w_count;
    logic [CW-1:0]                 w_rem_frames;
    logic [CW-1:0]                 w_cg;
    logic [CW-1:0]                 w_n;
    logic [swmn_pkg::GC_W-1:0]     w_gc_eff;
    logic signed [SB-1:0]          w_s;
    logic signed [SB-1:0]          w_wsum;
    logic signed [SB-1:0]          w_hsub;
    logic signed [swmn_pkg::GSUM_W-1:0] w_gsum_eff;
    logic [HAW:0]                  w_base_inc;
    logic [AW-1:0]                 w_mag;
    logic [AW-1:0]                 w_rem0;
    logic [AW-1:0]                 w_div_lim;
    logic                          w_ge;
    logic signed [FW-1:0]          w_result;

    assign w_in_ok   = {1'b0, i_dim} < (swmn_pkg::DIM_W + 1)'(FD);
    assign w_cur_idx = r_d[FAW-1:0];
    assign w_cur_ok  = {1'b0, r_d} < (swmn_pkg::DIM_W + 1)'(FD);

    assign w_sum_we = (i_cmd.op == swmn_pkg::OP_SUM);
    assign w_g_we   = i_cmd.in_accept && (i_mode == swmn_pkg::MODE_LOAD) && w_in_ok;

    swmn_ram #(.WIDTH(SB), .DEPTH(FD)) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (w_sum_we),
        .i_waddr (w_cur_idx),
        .i_wdata (w_s),
        .i_raddr (w_cur_idx),
        .o_rdata (w_wrdata)
    );

    swmn_ram #(.WIDTH(swmn_pkg::GSUM_W), .DEPTH(FD)) u_glob_ram (
        .i_clk   (i_clk),
        .i_we    (w_g_we),
        .i_waddr (i_dim[FAW-1:0]),
        .i_wdata (i_gsum),
        .i_raddr (w_cur_idx),
        .o_rdata (w_grdata)
    );

    swmn_ram #(.WIDTH(FW), .DEPTH(swmn_pkg::HIST_DEPTH)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_sum_we),
        .i_waddr (r_hist_addr),
        .i_wdata (r_x),
        .i_raddr (r_hist_addr),
        .o_rdata (w_hrdata)
    );

    // Window count and the number of prior frames blended in.
    assign w_full       = (r_frames == CW'(WF));
    assign w_count      = w_full ? CW'(WF) : r_frames + 1'b1;
    assign w_rem_frames = CW'(WF) - w_count;
    assign w_cg = (swmn_pkg::CG_CMP_W'(w_rem_frames) > swmn_pkg::CG_CMP_W'(r_smooth)) ?
                  CW'(r_smooth) : w_rem_frames;
    assign w_n      = w_count + w_cg;
    assign w_gc_eff = (r_gc == '0) ? swmn_pkg::GC_W'(1) : r_gc;

    assign w_wsum     = r_wvalid[w_cur_idx] ? $signed(w_wrdata) : '0;
    assign w_hsub     = w_full ? SB'($signed(w_hrdata)) : '0;
    assign w_s        = w_wsum + SB'(r_x) - w_hsub;
    assign w_gsum_eff = r_gvalid[w_cur_idx] ? $signed(w_grdata) : '0;

    assign w_base_inc = {1'b0, r_base} + (HAW + 1)'(FD);
    assign w_close = (i_cmd.in_accept && (i_mode == swmn_pkg::MODE_FEAT) && !w_in_ok && i_last)
                  || ((i_cmd.op == swmn_pkg::OP_OUT) && r_last);

    assign w_mag     = r_m[AW-1] ? (AW'(0) - r_m) : r_m;
    assign w_rem0    = {w_mag[AW-2:0], 1'b0} + AW'(r_den);
    assign w_div_lim = AW'({r_den, 1'b0}) << (swmn_pkg::DIV_SHIFT + 1);
    assign w_ge      = (r_rem >= r_dsh);

    // A quotient too wide for the divider saturates like any other large one.
    always_comb begin
        if (r_neg) begin
            w_result = (r_ovf || (r_q > QW'(32768))) ? FW'(-32768) : FW'(QW'(0) - r_q);
        end else begin
            w_result = (r_ovf || (r_q > QW'(32767))) ? FW'(32767) : FW'(r_q);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth    <= swmn_pkg::SMOOTH_RESET;
            r_gc        <= swmn_pkg::GC_RESET;
            r_frames    <= '0;
            r_base      <= '0;
            r_wvalid    <= '0;
            r_gvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    swmn_pkg::CFG_SMOOTH: r_smooth <= i_cfg_data[swmn_pkg::SMOOTH_W-1:0];
                    swmn_pkg::CFG_GCOUNT: r_gc     <= i_cfg_data[swmn_pkg::GC_W-1:0];
                    default: ;
                endcase
            end
            if (w_g_we) begin
                r_gvalid[i_dim[FAW-1:0]] <= 1'b1;
            end
            if (w_sum_we) begin
                r_wvalid[w_cur_idx] <= 1'b1;
            end
            if (i_cmd.in_accept && (i_mode == swmn_pkg::MODE_NEW)) begin
                r_wvalid <= '0;
                r_frames <= '0;
                r_base   <= '0;
            end else if (w_close) begin
                r_base <= (w_base_inc >= (HAW + 1)'(swmn_pkg::HIST_DEPTH)) ?
                          '0 : w_base_inc[HAW-1:0];
                if (!w_full) begin
                    r_frames <= r_frames + 1'b1;
                end
            end
            if (i_cmd.op == swmn_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and arithmetic registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_accept) begin
            r_d         <= i_dim;
            r_x         <= i_feat;
            r_last      <= i_last;
            r_hist_addr <= r_base + HAW'(i_dim);
        end
        case (i_cmd.op)
            swmn_pkg::OP_SUM: begin
                r_s   <= w_s;
                r_cg  <= w_cg;
                r_ma  <= AW'(w_gc_eff);
                r_mb  <= DW'(w_n);
                r_acc <= '0;
            end
            swmn_pkg::OP_MSTEP: begin
                if (r_mb[0]) begin
                    r_acc <= r_acc + r_ma;
                end
                r_ma <= r_ma << 1;
                r_mb <= r_mb >> 1;
            end
            swmn_pkg::OP_DEN: begin
                r_den <= r_acc[DW-1:0];
                r_ma  <= AW'(r_s);
                r_mb  <= DW'(w_gc_eff);
                r_acc <= '0;
            end
            swmn_pkg::OP_T1: begin
                r_num <= r_acc;
                r_ma  <= AW'(w_gsum_eff);
                r_mb  <= DW'(r_cg);
                r_acc <= '0;
            end
            swmn_pkg::OP_T2: begin
                r_num <= r_num + r_acc;
                r_ma  <= AW'(r_x);
                r_mb  <= r_den;
                r_acc <= '0;
            end
            swmn_pkg::OP_T3: begin
                r_m <= r_acc - r_num;
            end
            swmn_pkg::OP_DPRE: begin
                // Rounded quotient is floor((2|m| + den) / (2 den)).
                r_rem  <= w_rem0;
                r_dsh  <= AW'({r_den, 1'b0}) << swmn_pkg::DIV_SHIFT;
                r_q    <= '0;
                r_dcnt <= swmn_pkg::DCNT_W'(swmn_pkg::DIV_SHIFT);
                r_neg  <= r_m[AW-1];
                r_ovf  <= (w_rem0 >= w_div_lim);
            end
            swmn_pkg::OP_DSTEP: begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q    <= {r_q[QW-2:0], w_ge};
                r_dsh  <= r_dsh >> 1;
                r_dcnt <= r_dcnt - 1'b1;
            end
            swmn_pkg::OP_OUT: begin
                r_out_dim   <= r_d;
                r_out_value <= w_result;
                r_out_last  <= r_last;
            end
            default: ;
        endcase
    end

    assign o_status.feat_start = (i_mode == swmn_pkg::MODE_FEAT) && w_in_ok;
    assign o_status.mul_zero   = (r_mb == '0);
    assign o_status.div_last   = (r_dcnt == '0) && w_cur_ok;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_dim   = r_out_dim;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

>>> rtl/core/swmn_ctrl.sv
// Controller state machine that sequences the datapath for one feature element.
module swmn_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  swmn_pkg::t_dp_status  i_status,
    output swmn_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_READ = 10'b00_0000_0010,
        S_SUM  = 10'b00_0000_0100,
        S_MDEN = 10'b00_0000_1000,
        S_MT1  = 10'b00_0001_0000,
        S_MT2  = 10'b00_0010_0000,
        S_MT3  = 10'b00_0100_0000,
        S_DPRE = 10'b00_1000_0000,
        S_DIV  = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    swmn_pkg::t_dp_op w_op;

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.in_accept = i_in_valid && o_in_ready;
    assign o_cmd.op        = w_op;

    always_comb begin
        n_state = r_state;
        w_op    = swmn_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_status.feat_start) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                w_op    = swmn_pkg::OP_SUM;
                n_state = S_MDEN;
            end
            S_MDEN: begin
                if (i_status.mul_zero) begin
                    w_op    = swmn_pkg::OP_DEN;
                    n_state = S_MT1;
                end else begin
                    w_op = swmn_pkg::OP_MSTEP;
                end
            end
            S_MT1: begin
                if (i_status.mul_zero) begin
                    w_op    = swmn_pkg::OP_T1;
                    n_state = S_MT2;
                end else begin
                    w_op = swmn_pkg::OP_MSTEP;
                end
            end
            S_MT2: begin
                if (i_status.mul_zero) begin
                    w_op    = swmn_pkg::OP_T2;
                    n_state = S_MT3;
                end else begin
                    w_op = swmn_pkg::OP_MSTEP;
                end
            end
            S_MT3: begin
                if (i_status.mul_zero) begin
                    w_op    = swmn_pkg::OP_T3;
                    n_state = S_DPRE;
                end else begin
                    w_op = swmn_pkg::OP_MSTEP;
                end
            end
            S_DPRE: begin
                w_op    = swmn_pkg::OP_DPRE;
                n_state = S_DIV;
            end
            S_DIV: begin
                w_op = swmn_pkg::OP_DSTEP;
                if (i_status.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    w_op    = swmn_pkg::OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/sliding_window_mean_normalizer.sv
// A feature element passes from transfer to the result register through the shared
// shift-add multiplier (one multiplier bit a cycle, four products) and the 18-step
// restoring divider, and waits before the result register while a result is not taken;
// loads, utterance starts and other items are taken without leaving the idle state.
// Throughput: one item at a time; the next is taken as soon as the result is registered.
// Reset (synchronous, active low) clears the window, the valid bits of the sum stores and
// the configuration to its defaults; no clearing pass is needed.
module sliding_window_mean_normalizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swmn_in_if.sink     i_in,
    swmn_out_if.source  o_out,
    swmn_cfg_if.sink    i_cfg
);

    swmn_pkg::t_dp_cmd    w_cmd;
    swmn_pkg::t_dp_status w_status;
    logic                 w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    swmn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    swmn_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_mode      (i_in.mode),
        .i_dim       (i_in.dim_index),
        .i_feat      (i_in.feature_value),
        .i_gsum      (i_in.global_sum_value),
        .i_last      (i_in.frame_last),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_dim   (o_out.out_dim_index),
        .o_out_value (o_out.normalized_value),
        .o_out_last  (o_out.out_frame_last)
    );

endmodule

>>> rtl/core/swmn_checker.sv
// Port-level checker for the mean normalizer, bound to the top level.
`include "assert_macros.svh"

module swmn_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic [swmn_pkg::MODE_W-1:0]  i_in_mode,
    input logic [swmn_pkg::DIM_W-1:0]   i_in_dim,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [swmn_pkg::DIM_W-1:0]   i_out_dim
);

    logic w_feat_take;
    logic w_out_dim_ok;

    assign w_feat_take = i_in_valid && i_in_ready && (i_in_mode == swmn_pkg::MODE_FEAT)
                      && ({1'b0, i_in_dim} < (swmn_pkg::DIM_W + 1)'(swmn_pkg::FEATURE_DIM));
    assign w_out_dim_ok = {1'b0, i_out_dim} < (swmn_pkg::DIM_W + 1)'(swmn_pkg::FEATURE_DIM);

    // A stalled result stays offered.
    `SWMN_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // Reset empties the result register.
    `SWMN_ASSERT_ALWAYS_NXT(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)
    // A feature element in range keeps the input closed while it is worked on.
    `SWMN_ASSERT_NXT(a_busy_after_feat, i_clk, i_rst_n, w_feat_take, !i_in_ready)
    // Results only name dimensions that exist.
    `SWMN_ASSERT_IMP(a_out_dim_range, i_clk, i_rst_n, i_out_valid, w_out_dim_ok)

endmodule

bind sliding_window_mean_normalizer swmn_checker u_swmn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_mode   (i_in.mode),
    .i_in_dim    (i_in.dim_index),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_dim   (o_out.out_dim_index)
);

>>> tb/sv/swmn_checker.sv
// Checker that predicts the normalizer's results from observed transfers and compares them.
module tb_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    swmn_in_if   in_ch,
    swmn_out_if  out_ch,
    swmn_cfg_if  cfg_ch,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [swmn_pkg::DIM_W-1:0]         dim;
        logic signed [swmn_pkg::FEAT_W-1:0] value;
        logic                               last;
    } t_norm_result;

    t_norm_result norm_q[$];

    logic signed [swmn_pkg::SUM_BITS-1:0] win_sum [swmn_pkg::FEATURE_DIM];
    logic [swmn_pkg::FEAT_W-1:0]          hist [swmn_pkg::HIST_DEPTH];
    logic signed [swmn_pkg::GSUM_W-1:0]   prior_sum [swmn_pkg::FEATURE_DIM];
    int unsigned                          frames_in_win;
    int unsigned                          ring_slot;
    logic [swmn_pkg::SMOOTH_W-1:0]        smooth_frames;
    logic [swmn_pkg::GC_W-1:0]            prior_frames;
    int                                   errors;

    assign o_errors  = errors;
    assign o_pending = norm_q.size();

    function automatic void close_frame();
        ring_slot = (ring_slot + 1 >= swmn_pkg::WINDOW_FRAMES) ? 0 : ring_slot + 1;
        if (frames_in_win < swmn_pkg::WINDOW_FRAMES) frames_in_win++;
    endfunction

    // Updates the window for one element and returns its normalized value.
    function automatic logic signed [swmn_pkg::FEAT_W-1:0] normalize(
            input logic [swmn_pkg::DIM_W-1:0] d,
            input logic signed [swmn_pkg::FEAT_W-1:0] x);
        longint s, cnt, cg, gc, den, num, m;
        longint unsigned mag, q;
        logic signed [swmn_pkg::SUM_BITS-1:0] wrapped;
        int slot;
        slot = ring_slot * swmn_pkg::FEATURE_DIM + d;
        s = longint'(win_sum[d]) + longint'(x);
        if (frames_in_win >= swmn_pkg::WINDOW_FRAMES) s -= longint'($signed(hist[slot]));
        wrapped = s[swmn_pkg::SUM_BITS-1:0];
        s = longint'(wrapped);
        win_sum[d] = wrapped;
        hist[slot] = x;
        cnt = (frames_in_win < swmn_pkg::WINDOW_FRAMES) ? frames_in_win + 1
                                                         : swmn_pkg::WINDOW_FRAMES;
        cg = 0;
        if (cnt < swmn_pkg::WINDOW_FRAMES) begin
            cg = swmn_pkg::WINDOW_FRAMES - cnt;
            if (cg > longint'(smooth_frames)) cg = longint'(smooth_frames);
        end
        gc = (prior_frames == 0) ? 1 : longint'(prior_frames);
        den = gc * (cnt + cg);
        num = s * gc + longint'(prior_sum[d]) * cg;
        m = longint'(x) * den - num;
        mag = (m < 0) ? longint'(0) - m : m;
        q = (2 * mag + den) / (2 * longint'(den));
        if (m < 0) return (q > 32768) ? -16'sd32768 : -q[swmn_pkg::FEAT_W-1:0];
        return (q > 32767) ? 16'sd32767 : q[swmn_pkg::FEAT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_norm_result r;
        t_norm_result e;
        if (!i_rst_n) begin
            foreach (win_sum[k]) win_sum[k] = '0;
            foreach (prior_sum[k]) prior_sum[k] = '0;
            frames_in_win = 0;
            ring_slot = 0;
            smooth_frames = swmn_pkg::SMOOTH_RESET;
            prior_frames = swmn_pkg::GC_RESET;
            errors = 0;
            norm_q.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == swmn_pkg::CFG_SMOOTH)
                    smooth_frames = cfg_ch.data[swmn_pkg::SMOOTH_W-1:0];
                else if (cfg_ch.index == swmn_pkg::CFG_GCOUNT)
                    prior_frames = cfg_ch.data;
            end
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.mode)
                    swmn_pkg::MODE_LOAD: begin
                        if (in_ch.dim_index < swmn_pkg::FEATURE_DIM)
                            prior_sum[in_ch.dim_index] = in_ch.global_sum_value;
                    end
                    swmn_pkg::MODE_NEW: begin
                        foreach (win_sum[k]) win_sum[k] = '0;
                        frames_in_win = 0;
                        ring_slot = 0;
                    end
                    swmn_pkg::MODE_FEAT: begin
                        if (in_ch.dim_index < swmn_pkg::FEATURE_DIM) begin
                            r.dim = in_ch.dim_index;
                            r.value = normalize(in_ch.dim_index, in_ch.feature_value);
                            r.last = in_ch.frame_last;
                            norm_q.push_back(r);
                        end
                        if (in_ch.frame_last) close_frame();
                    end
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (norm_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: dim %0d value %0d last %0d",
                                 out_ch.out_dim_index, out_ch.normalized_value,
                                 out_ch.out_frame_last);
                end else begin
                    e = norm_q.pop_front();
                    if (e.dim !== out_ch.out_dim_index || e.value !== out_ch.normalized_value
                            || e.last !== out_ch.out_frame_last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected dim %0d value %0d last %0d, got %0d %0d %0d",
                                     e.dim, e.value, e.last, out_ch.out_dim_index,
                                     out_ch.normalized_value, out_ch.out_frame_last);
                    end
                end
            end
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the testbench: stimulus, flow control and verdict for the mean normalizer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [swmn_pkg::MODE_W-1:0] MODE_IGNORED = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   snd_idle;
    int   rcv_idle;
    bit   want_hold = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_cnt = 0;

    // Stimulus-side view of the window, used only to keep history reads on written slots.
    bit          slot_written [swmn_pkg::HIST_DEPTH];
    int unsigned stim_frames = 0;
    int unsigned stim_ring = 0;

    swmn_in_if  in_ch();
    swmn_out_if out_ch();
    swmn_cfg_if cfg_ch();

    sliding_window_mean_normalizer u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    tb_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_ch   (cfg_ch),
        .o_errors (errors),
        .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The long hold-off lets the block fill up and push back on its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end else if (want_hold && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    task automatic send_item(input logic [swmn_pkg::MODE_W-1:0] mode,
                             input logic [swmn_pkg::DIM_W-1:0] d,
                             input logic [swmn_pkg::FEAT_W-1:0] x,
                             input logic [swmn_pkg::GSUM_W-1:0] g,
                             input logic last);
        while ($urandom_range(0, 99) < snd_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.dim_index <= d;
        in_ch.feature_value <= x;
        in_ch.global_sum_value <= g;
        in_ch.frame_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (mode == swmn_pkg::MODE_NEW) begin
            stim_frames = 0;
            stim_ring = 0;
        end else if (mode == swmn_pkg::MODE_FEAT) begin
            if (d < swmn_pkg::FEATURE_DIM)
                slot_written[stim_ring * swmn_pkg::FEATURE_DIM + d] = 1'b1;
            if (last) begin
                stim_ring = (stim_ring + 1 >= swmn_pkg::WINDOW_FRAMES) ? 0 : stim_ring + 1;
                if (stim_frames < swmn_pkg::WINDOW_FRAMES) stim_frames++;
            end
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [swmn_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swmn_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [swmn_pkg::FEAT_W-1:0] rand_feature();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return swmn_pkg::FEAT_W'($urandom());
        endcase
    endfunction

    function automatic logic [swmn_pkg::GSUM_W-1:0] rand_gsum();
        return swmn_pkg::GSUM_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [swmn_pkg::DIM_W-1:0] rand_dim();
        return swmn_pkg::DIM_W'($urandom());
    endfunction

    // A full window reads back the slot it replaces, so only written slots are chosen then.
    function automatic logic [swmn_pkg::DIM_W-1:0] pick_dim();
        logic [swmn_pkg::DIM_W-1:0] d;
        d = ($urandom_range(0, 19) == 0) ?
            swmn_pkg::DIM_W'($urandom_range(swmn_pkg::FEATURE_DIM, 127)) :
            swmn_pkg::DIM_W'($urandom_range(0, swmn_pkg::FEATURE_DIM - 1));
        if (stim_frames >= swmn_pkg::WINDOW_FRAMES && d < swmn_pkg::FEATURE_DIM
                && !slot_written[stim_ring * swmn_pkg::FEATURE_DIM + d])
            d = slot_written[stim_ring * swmn_pkg::FEATURE_DIM] ? '0 : 7'd100;
        return d;
    endfunction

    task automatic random_traffic(input int n_items, input bit allow_new);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 3 && allow_new) begin
                send_item(swmn_pkg::MODE_NEW, rand_dim(), rand_feature(), rand_gsum(),
                          1'($urandom()));
                sent++;
            end else if (pick < 12) begin
                send_item(swmn_pkg::MODE_LOAD, swmn_pkg::DIM_W'($urandom_range(0, 44)),
                          rand_feature(), rand_gsum(), 1'($urandom()));
                sent++;
            end else if (pick < 15) begin
                send_item(MODE_IGNORED, rand_dim(), rand_feature(), rand_gsum(),
                          1'($urandom()));
            end else begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    send_item(swmn_pkg::MODE_FEAT, pick_dim(), rand_feature(), rand_gsum(),
                              k == len - 1 || $urandom_range(0, 29) == 0);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        in_ch.valid <= 1'b0;
        in_ch.mode <= swmn_pkg::MODE_LOAD;
        in_ch.dim_index <= '0;
        in_ch.feature_value <= '0;
        in_ch.global_sum_value <= '0;
        in_ch.frame_last <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= swmn_pkg::CFG_SMOOTH;
        cfg_ch.data <= '0;
        i_rst_n <= 1'b0;
        snd_idle = 19;
        rcv_idle = 76;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under reset configuration.
        send_item(swmn_pkg::MODE_LOAD, 7'd0, '0, 48'h7FFF_FFFF_FFFF, 1'b0);
        send_item(swmn_pkg::MODE_LOAD, 7'd1, '0, 48'h8000_0000_0000, 1'b0);
        send_item(swmn_pkg::MODE_LOAD, swmn_pkg::DIM_W'(swmn_pkg::FEATURE_DIM - 1), '0,
                  48'hFFFF_FFFF_FFFF, 1'b1);
        send_item(swmn_pkg::MODE_LOAD, 7'd127, '0, 48'h1234_5678_9ABC, 1'b0);
        send_item(swmn_pkg::MODE_FEAT, 7'd0, 16'h7FFF, '0, 1'b0);
        send_item(swmn_pkg::MODE_FEAT, 7'd1, 16'h8000, '0, 1'b0);
        send_item(swmn_pkg::MODE_FEAT, swmn_pkg::DIM_W'(swmn_pkg::FEATURE_DIM - 1), 16'h0000,
                  '0, 1'b0);
        send_item(swmn_pkg::MODE_FEAT, 7'd0, 16'hFFFF, '0, 1'b0);
        send_item(swmn_pkg::MODE_FEAT, swmn_pkg::DIM_W'(swmn_pkg::FEATURE_DIM), 16'h1234,
                  '0, 1'b1);
        send_item(swmn_pkg::MODE_FEAT, 7'd127, 16'h5555, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_item(MODE_IGNORED, 7'd127, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_item(swmn_pkg::MODE_FEAT, 7'd2, 16'h0100, '0, 1'b1);
        send_item(swmn_pkg::MODE_NEW, 7'd127, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_item(swmn_pkg::MODE_FEAT, 7'd1, 16'h8000, '0, 1'b1);
        random_traffic(40, 1'b1);
        drain();

        write_reg(swmn_pkg::CFG_SMOOTH, 32'd0);
        write_reg(swmn_pkg::CFG_GCOUNT, 32'd0);
        snd_idle = 76;
        rcv_idle = 19;
        want_hold = 1'b1;
        random_traffic(40, 1'b1);
        drain();

        // Fill the window with one-element frames so that every ring slot of dimension 0
        // is written before the window wraps.
        write_reg(swmn_pkg::CFG_SMOOTH, 32'd4096);
        write_reg(swmn_pkg::CFG_GCOUNT, 32'd12345);
        snd_idle = 0;
        rcv_idle = 0;
        send_item(swmn_pkg::MODE_NEW, '0, '0, '0, 1'b0);
        for (int f = 0; f < swmn_pkg::WINDOW_FRAMES + 3; f++)
            send_item(swmn_pkg::MODE_FEAT, '0, rand_feature(), '0, 1'b1);
        drain();

        write_reg(swmn_pkg::CFG_SMOOTH, 32'h1FFF);
        write_reg(swmn_pkg::CFG_GCOUNT, 32'hFFFF_FFFF);
        random_traffic(30, 1'b0);
        drain();
        repeat (200) @(posedge i_clk);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sliding_window_mean_normalizer.f
+incdir+rtl/core
rtl/core/swmn_pkg.sv
rtl/core/swmn_if.sv
rtl/core/swmn_ram.sv
rtl/core/swmn_datapath.sv
rtl/core/swmn_ctrl.sv
rtl/core/sliding_window_mean_normalizer.sv
rtl/core/swmn_checker.sv
tb/sv/swmn_checker.sv
tb/sv/tb_top.sv
